// File: hdl/pbts_pkg.sv
// Shared types and codes of the priority bitmap task scheduler.
package pbts_pkg;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  task_id;
        logic [4:0]  task_priority;
        logic [31:0] delay_ticks;
    } pbts_in_t;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [4:0]  run_task;
        logic        switch_now;
        logic [31:0] woken_mask;
        logic [7:0]  lock_level;
        logic [31:0] tick_total;
    } pbts_out_t;

    // Request codes.
    typedef enum logic [2:0] {
        REQ_READY    = 3'd0,
        REQ_UNREADY  = 3'd1,
        REQ_DELAY    = 3'd2,
        REQ_WAKE     = 3'd3,
        REQ_TICK     = 3'd4,
        REQ_LOCK     = 3'd5,
        REQ_UNLOCK   = 3'd6,
        REQ_SCHEDULE = 3'd7
    } pbts_req_t;

    // Datapath operations, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DELAY,
        OP_WAKE,
        OP_LOCK,
        OP_UNLOCK,
        OP_RM_LOOK,
        OP_RM_LINK,
        OP_ADD_LOOK,
        OP_ADD_LINK,
        OP_SCAN,
        OP_SLICE,
        OP_FIND,
        OP_PICK,
        OP_OUT
    } pbts_op_t;

    // Which task a queue operation works on.
    typedef enum logic [1:0] {
        TSEL_REQ,
        TSEL_SCAN,
        TSEL_RUN
    } pbts_tsel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RM_LOOK,
        ST_RM_LINK,
        ST_ADD_LOOK,
        ST_ADD_LINK,
        ST_SCAN,
        ST_SLICE,
        ST_FIND,
        ST_PICK,
        ST_FIN
    } pbts_state_t;

    // What a queue sequence is doing, so it knows where to return.
    typedef enum logic [1:0] {
        PH_READY,
        PH_UNREADY,
        PH_SCAN,
        PH_ROTATE
    } pbts_phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        pbts_op_t   op;
        pbts_tsel_t tsel;
        logic       at_head;
        logic       new_prio;
        logic       scan_inc;
    } pbts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        pbts_req_t req;
        logic      tid_ok;
        logic      scan_expire;
        logic      scan_last;
        logic      slice_rotate;
        logic      lock_zero;
        logic      unlock_to_zero;
        logic      out_free;
    } pbts_status_t;

    localparam logic [7:0] LOCK_MAX    = 8'd255;
    localparam logic [7:0] SLICE_RESET = 8'd10;

endpackage

// File: hdl/pbts_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module pbts_ctrl
    import pbts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  pbts_status_t status,
    output pbts_cmd_t    cmd
);

    pbts_state_t state_reg, state_next;
    pbts_phase_t phase_reg, phase_next;

    // State and phase registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_READY;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        in_ready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.tsel     = TSEL_REQ;
        cmd.at_head  = 1'b1;
        cmd.new_prio = 1'b0;
        cmd.scan_inc = 1'b0;
        unique case (phase_reg)
            PH_SCAN:   cmd.tsel = TSEL_SCAN;
            PH_ROTATE: cmd.tsel = TSEL_RUN;
            default:   cmd.tsel = TSEL_REQ;
        endcase
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.req) inside
                    REQ_READY, REQ_UNREADY:
                    begin
                        phase_next = (status.req == REQ_READY) ? PH_READY : PH_UNREADY;
                        state_next = status.tid_ok ? ST_RM_LOOK : ST_FIN;
                    end
                    REQ_DELAY:
                    begin
                        cmd.op     = OP_DELAY;
                        state_next = ST_FIN;
                    end
                    REQ_WAKE:
                    begin
                        cmd.op     = OP_WAKE;
                        state_next = ST_FIN;
                    end
                    REQ_TICK:
                    begin
                        phase_next = PH_SCAN;
                        state_next = ST_SCAN;
                    end
                    REQ_LOCK:
                    begin
                        cmd.op     = OP_LOCK;
                        state_next = ST_FIN;
                    end
                    REQ_UNLOCK:
                    begin
                        cmd.op     = OP_UNLOCK;
                        state_next = status.unlock_to_zero ? ST_FIND : ST_FIN;
                    end
                    default:
                    begin
                        state_next = ST_FIND;
                    end
                endcase
            end
            ST_RM_LOOK:
            begin
                cmd.op     = OP_RM_LOOK;
                state_next = ST_RM_LINK;
            end
            ST_RM_LINK:
            begin
                cmd.op     = OP_RM_LINK;
                state_next = (phase_reg == PH_UNREADY) ? ST_FIN : ST_ADD_LOOK;
            end
            ST_ADD_LOOK:
            begin
                cmd.op       = OP_ADD_LOOK;
                cmd.new_prio = (phase_reg == PH_READY);
                state_next   = ST_ADD_LINK;
            end
            ST_ADD_LINK:
            begin
                cmd.op      = OP_ADD_LINK;
                cmd.at_head = (phase_reg != PH_ROTATE);
                unique case (phase_reg)
                    PH_SCAN:
                    begin
                        cmd.scan_inc = 1'b1;
                        state_next   = status.scan_last ? ST_SLICE : ST_SCAN;
                    end
                    PH_ROTATE: state_next = ST_FIND;
                    default:   state_next = ST_FIN;
                endcase
            end
            ST_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (status.scan_expire)
                begin
                    state_next = ST_RM_LOOK;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = status.scan_last ? ST_SLICE : ST_SCAN;
                end
            end
            ST_SLICE:
            begin
                cmd.op = OP_SLICE;
                if (status.slice_rotate)
                begin
                    phase_next = PH_ROTATE;
                    state_next = ST_RM_LOOK;
                end
                else
                begin
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (status.lock_zero)
                begin
                    cmd.op     = OP_FIND;
                    state_next = ST_PICK;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_PICK:
            begin
                cmd.op     = OP_PICK;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/pbts_datapath.sv
// Datapath of the scheduler: ready queues, delay counters, slices and result register.
module pbts_datapath
    import pbts_pkg::*;
#(
    parameter int NUM_TASKS      = 32,
    parameter int NUM_PRIORITIES = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  pbts_in_t     in_data,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_data,
    input  pbts_cmd_t    cmd,
    output pbts_status_t status,
    output logic         out_valid,
    input  logic         out_ready,
    output pbts_out_t    out_data
);

    localparam int TW = $clog2(NUM_TASKS);
    localparam int PW = $clog2(NUM_PRIORITIES);
    localparam int CW = $clog2(NUM_TASKS + 1);

    // Control state.
    logic [7:0]          slice_length_reg;
    logic [NUM_PRIORITIES-1:0] bitmap_reg;
    logic [CW-1:0]       count_reg [NUM_PRIORITIES];
    logic [NUM_TASKS-1:0] delayed_reg;
    logic [NUM_TASKS-1:0] inq_reg;
    logic [7:0]          slice_reg [NUM_TASKS];
    logic [TW-1:0]       running_reg;
    logic [7:0]          lock_reg;
    logic [31:0]         tick_reg;
    logic                out_valid_reg;

    // Storage without reset.
    logic [TW-1:0]       head_mem [NUM_PRIORITIES];
    logic [TW-1:0]       tail_mem [NUM_PRIORITIES];
    logic [TW-1:0]       next_mem [NUM_TASKS];
    logic [TW-1:0]       prev_mem [NUM_TASKS];
    logic [PW-1:0]       prio_mem [NUM_TASKS];
    logic [31:0]         dcnt_mem [NUM_TASKS];

    // Per-request working registers.
    pbts_in_t            req_reg;
    logic [31:0]         woken_reg;
    logic                sw_reg;
    logic [TW-1:0]       scan_reg;
    logic [PW-1:0]       p_reg;
    logic [TW-1:0]       pv_reg;
    logic [TW-1:0]       nx_reg;
    logic                inq_l_reg;
    logic                any_reg;
    pbts_out_t           out_data_reg;

    logic [TW-1:0]       t_req;
    logic [TW-1:0]       t_sel;
    logic [PW-1:0]       prio_sat;
    logic                tid_ok;
    logic [PW-1:0]       ffs_p;
    logic                ffs_any;
    logic [TW-1:0]       pick;

    // Request decoding.
    assign t_req    = TW'(req_reg.task_id);
    assign tid_ok   = (32'(req_reg.task_id) < NUM_TASKS);
    assign prio_sat = (32'(req_reg.task_priority) >= NUM_PRIORITIES) ?
                      PW'(NUM_PRIORITIES - 1) : PW'(req_reg.task_priority);
    assign pick     = head_mem[p_reg];

    // Task selection for queue operations.
    always_comb
    begin
        case (cmd.tsel)
            TSEL_SCAN: t_sel = scan_reg;
            TSEL_RUN:  t_sel = running_reg;
            default:   t_sel = t_req;
        endcase
    end

    // Lowest-numbered non-empty priority.
    always_comb
    begin
        ffs_p   = '0;
        ffs_any = 1'b0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
        begin
            if (bitmap_reg[i])
            begin
                ffs_p   = PW'(i);
                ffs_any = 1'b1;
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.req            = pbts_req_t'(req_reg.req_type);
        status.tid_ok         = tid_ok;
        status.scan_expire    = delayed_reg[scan_reg] && (dcnt_mem[scan_reg] == 32'd1);
        status.scan_last      = (32'(scan_reg) == NUM_TASKS - 1);
        status.slice_rotate   = (slice_reg[running_reg] == 8'd1) && inq_reg[running_reg] &&
                                (count_reg[prio_mem[running_reg]] > CW'(1));
        status.lock_zero      = (lock_reg == 8'd0);
        status.unlock_to_zero = (lock_reg == 8'd1);
        status.out_free       = !out_valid_reg || out_ready;
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_length_reg <= SLICE_RESET;
            bitmap_reg       <= '0;
            delayed_reg      <= '0;
            inq_reg          <= '0;
            running_reg      <= TW'(NUM_TASKS - 1);
            lock_reg         <= 8'd0;
            tick_reg         <= 32'd0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++)
            begin
                count_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                slice_reg[i] <= SLICE_RESET;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                slice_length_reg <= cfg_data;
            end
            // The output register fills on the final step and empties on a transfer.
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_DELAY:
                begin
                    if (tid_ok)
                    begin
                        delayed_reg[t_req] <= 1'b1;
                    end
                end
                OP_WAKE:
                begin
                    if (tid_ok)
                    begin
                        delayed_reg[t_req] <= 1'b0;
                    end
                end
                OP_LOCK:
                begin
                    if (lock_reg != LOCK_MAX)
                    begin
                        lock_reg <= lock_reg + 8'd1;
                    end
                end
                OP_UNLOCK:
                begin
                    if (lock_reg != 8'd0)
                    begin
                        lock_reg <= lock_reg - 8'd1;
                    end
                end
                OP_RM_LINK:
                begin
                    if (inq_l_reg)
                    begin
                        if (count_reg[p_reg] != '0)
                        begin
                            count_reg[p_reg] <= count_reg[p_reg] - CW'(1);
                        end
                        bitmap_reg[p_reg] <= (count_reg[p_reg] > CW'(1));
                        inq_reg[t_sel]    <= 1'b0;
                    end
                end
                OP_ADD_LINK:
                begin
                    count_reg[p_reg]  <= count_reg[p_reg] + CW'(1);
                    bitmap_reg[p_reg] <= 1'b1;
                    inq_reg[t_sel]    <= 1'b1;
                end
                OP_SCAN:
                begin
                    if (status.scan_expire)
                    begin
                        delayed_reg[scan_reg] <= 1'b0;
                    end
                end
                OP_SLICE:
                begin
                    if (slice_reg[running_reg] == 8'd1)
                    begin
                        slice_reg[running_reg] <= slice_length_reg;
                    end
                    else
                    begin
                        slice_reg[running_reg] <= slice_reg[running_reg] - 8'd1;
                    end
                    tick_reg <= tick_reg + 32'd1;
                end
                OP_PICK:
                begin
                    if (any_reg && (pick != running_reg))
                    begin
                        running_reg <= pick;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Queue links, priorities, delay counters and working registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                req_reg   <= in_data;
                woken_reg <= 32'd0;
                sw_reg    <= 1'b0;
                scan_reg  <= '0;
            end
            OP_DELAY:
            begin
                if (tid_ok)
                begin
                    dcnt_mem[t_req] <= (req_reg.delay_ticks == 32'd0) ?
                                       32'd1 : req_reg.delay_ticks;
                end
            end
            OP_RM_LOOK:
            begin
                p_reg     <= prio_mem[t_sel];
                pv_reg    <= prev_mem[t_sel];
                nx_reg    <= next_mem[t_sel];
                inq_l_reg <= inq_reg[t_sel];
            end
            OP_RM_LINK:
            begin
                if (inq_l_reg)
                begin
                    if (head_mem[p_reg] == t_sel)
                    begin
                        head_mem[p_reg] <= nx_reg;
                    end
                    else
                    begin
                        next_mem[pv_reg] <= nx_reg;
                    end
                    if (tail_mem[p_reg] == t_sel)
                    begin
                        tail_mem[p_reg] <= pv_reg;
                    end
                    else
                    begin
                        prev_mem[nx_reg] <= pv_reg;
                    end
                end
            end
            OP_ADD_LOOK:
            begin
                if (cmd.new_prio)
                begin
                    prio_mem[t_sel] <= prio_sat;
                    p_reg           <= prio_sat;
                end
                else
                begin
                    p_reg <= prio_mem[t_sel];
                end
            end
            OP_ADD_LINK:
            begin
                if (count_reg[p_reg] == '0)
                begin
                    head_mem[p_reg] <= t_sel;
                    tail_mem[p_reg] <= t_sel;
                end
                else if (cmd.at_head)
                begin
                    next_mem[t_sel]           <= head_mem[p_reg];
                    prev_mem[head_mem[p_reg]] <= t_sel;
                    head_mem[p_reg]           <= t_sel;
                end
                else
                begin
                    prev_mem[t_sel]           <= tail_mem[p_reg];
                    next_mem[tail_mem[p_reg]] <= t_sel;
                    tail_mem[p_reg]           <= t_sel;
                end
                if (cmd.scan_inc)
                begin
                    scan_reg <= scan_reg + TW'(1);
                end
            end
            OP_SCAN:
            begin
                if (delayed_reg[scan_reg])
                begin
                    dcnt_mem[scan_reg] <= dcnt_mem[scan_reg] - 32'd1;
                end
                if (status.scan_expire)
                begin
                    woken_reg <= woken_reg | (32'd1 << scan_reg);
                end
                if (cmd.scan_inc)
                begin
                    scan_reg <= scan_reg + TW'(1);
                end
            end
            OP_FIND:
            begin
                p_reg   <= ffs_p;
                any_reg <= ffs_any;
            end
            OP_PICK:
            begin
                sw_reg <= any_reg && (pick != running_reg);
            end
            OP_OUT:
            begin
                out_data_reg.run_task   <= 5'(running_reg);
                out_data_reg.switch_now <= sw_reg;
                out_data_reg.woken_mask <= woken_reg;
                out_data_reg.lock_level <= lock_reg;
                out_data_reg.tick_total <= tick_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hdl/priority_bitmap_task_scheduler_core.sv
// Top level of the priority bitmap task scheduler.
// One request is worked on at a time, and the next is taken while the previous result
// still waits in the output register. Ready removes and requeues its task, unready
// only removes it, unlock also picks anew when the lock drops to zero, and schedule
// picks the next task unless locked. A tick walks every delay counter one per cycle
// through the single scan step, pausing to requeue each expired task, and rotates the
// running task behind its equal-priority peers when its slice ends. Each queue change
// runs as a look-up step followed by a link step on the shared queue tables.
module priority_bitmap_task_scheduler_core
    import pbts_pkg::*;
#(
    parameter int NUM_TASKS      = 32,
    parameter int NUM_PRIORITIES = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pbts_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pbts_out_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    pbts_cmd_t    cmd;
    pbts_status_t status;

    // The slice length register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    pbts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pbts_datapath #(
        .NUM_TASKS      (NUM_TASKS),
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Only one request is in flight: a transfer in is never followed by another at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a request is still in work");

    // A task switch can only be reported while the scheduler is unlocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.switch_now |-> out_data.lock_level == 8'd0)
        else $error("switch reported while locked");

    // A result stays valid until it has left; the next is only loaded once it leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

endmodule
